[design/ast_pkg.sv]
// Shared types, sizes and codes of the attribute span table.
package ast_pkg;

    // Table sizes and position width.
    localparam int SPAN_ENTRIES = 64;
    localparam int MAX_ACTIVE   = 16;
    localparam int POS_BITS     = 16;
    localparam int WORK_CAP     = 2 * SPAN_ENTRIES + 2;

    localparam int TA_BITS  = $clog2(SPAN_ENTRIES);
    localparam int CNT_BITS = $clog2(SPAN_ENTRIES + 1);
    localparam int WB_BITS  = $clog2(WORK_CAP);
    localparam int AI_BITS  = $clog2(MAX_ACTIVE);
    localparam int NA_BITS  = $clog2(MAX_ACTIVE + 1);

    // Command codes.
    localparam logic [2:0] CMD_RESET   = 3'd0;
    localparam logic [2:0] CMD_EXTEND  = 3'd1;
    localparam logic [2:0] CMD_ADD     = 3'd2;
    localparam logic [2:0] CMD_CLEAR   = 3'd3;
    localparam logic [2:0] CMD_REPLACE = 3'd4;
    localparam logic [2:0] CMD_READ    = 3'd5;

    // Result status codes.
    localparam logic [1:0] RSP_OK    = 2'd0;
    localparam logic [1:0] RSP_FULL  = 2'd1;
    localparam logic [1:0] RSP_RANGE = 2'd2;

    // Controller states; the datapath decodes them as its operation.
    localparam int ST_BITS = 5;
    localparam logic [ST_BITS-1:0] ST_IDLE   = 5'd0;
    localparam logic [ST_BITS-1:0] ST_DEC    = 5'd1;
    localparam logic [ST_BITS-1:0] ST_G_INIT = 5'd2;
    localparam logic [ST_BITS-1:0] ST_G_RD   = 5'd3;
    localparam logic [ST_BITS-1:0] ST_G_W1   = 5'd4;
    localparam logic [ST_BITS-1:0] ST_G_W2   = 5'd5;
    localparam logic [ST_BITS-1:0] ST_S_INIT = 5'd6;
    localparam logic [ST_BITS-1:0] ST_S_KEY  = 5'd7;
    localparam logic [ST_BITS-1:0] ST_S_KLD  = 5'd8;
    localparam logic [ST_BITS-1:0] ST_S_RDJ  = 5'd9;
    localparam logic [ST_BITS-1:0] ST_S_CHK  = 5'd10;
    localparam logic [ST_BITS-1:0] ST_S_PUT  = 5'd11;
    localparam logic [ST_BITS-1:0] ST_M_INIT = 5'd12;
    localparam logic [ST_BITS-1:0] ST_M_RD   = 5'd13;
    localparam logic [ST_BITS-1:0] ST_M_GRP  = 5'd14;
    localparam logic [ST_BITS-1:0] ST_M_PRN  = 5'd15;
    localparam logic [ST_BITS-1:0] ST_M_SCAN = 5'd16;
    localparam logic [ST_BITS-1:0] ST_M_ACT  = 5'd17;
    localparam logic [ST_BITS-1:0] ST_CHK    = 5'd18;
    localparam logic [ST_BITS-1:0] ST_C_RD   = 5'd19;
    localparam logic [ST_BITS-1:0] ST_C_WR   = 5'd20;
    localparam logic [ST_BITS-1:0] ST_R_RD   = 5'd21;
    localparam logic [ST_BITS-1:0] ST_FIN    = 5'd22;

    // Input word.
    typedef struct packed {
        logic [2:0]          command;
        logic [POS_BITS-1:0] range_start;
        logic [POS_BITS-1:0] range_end;
        logic [POS_BITS-1:0] count;
        logic [7:0]          attr_kind;
        logic [31:0]         attr_value;
        logic [5:0]          span_index;
    } ast_cmd_t;

    // Output word.
    typedef struct packed {
        logic [1:0]          status;
        logic [CNT_BITS-1:0] span_count;
        logic [POS_BITS-1:0] text_length;
        logic [POS_BITS-1:0] span_start;
        logic [POS_BITS-1:0] span_end;
        logic [7:0]          span_kind;
        logic [31:0]         span_value;
    } ast_rsp_t;

    // One table entry.
    typedef struct packed {
        logic [POS_BITS-1:0] lo;
        logic [POS_BITS-1:0] hi;
        logic [7:0]          kind;
        logic [31:0]         value;
    } ast_span_t;

    // Controller to datapath.
    typedef struct packed {
        logic [ST_BITS-1:0] op;
        logic               take;
        logic               give;
    } ast_ctrl_t;

    // Datapath to controller.
    typedef struct packed {
        logic is_table;
        logic is_read;
        logic is_merge;
        logic g_done;
        logic two_emit;
        logic s_done;
        logic j_zero;
        logic key_gt;
        logic r_done;
        logic new_grp;
        logic p_done;
        logic a_done;
        logic fits;
        logic c_done;
    } ast_stat_t;

endpackage

[design/attribute_span_table_core.sv]
// Top level of the attribute span table: controller plus datapath.
//
// The block holds a text length and up to 64 attribute spans sorted by start, and
// answers every command word with one result word. It works on one command at a
// time. Reset, extend, unused codes and read make no pass over the work buffer. Add,
// clear and replace run through the work buffer memory one entry per step: they
// build a work list from the old spans, sort it by start with an insertion sort,
// merge it in a walk that tracks at most 16 spans (add and replace only), check
// that it fits and copy it back into the table. The walks over the work buffer set
// the cost of these commands. A new command is taken while the last result still
// waits on the output.
module attribute_span_table_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  ast_pkg::ast_cmd_t cmd,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output ast_pkg::ast_rsp_t rsp
);

    ast_pkg::ast_ctrl_t ctl;
    ast_pkg::ast_stat_t stat;

    // Sequencer.
    ast_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    // Table and work buffer.
    ast_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .cmd   (cmd),
        .stat  (stat),
        .rsp   (rsp)
    );

endmodule

[design/ast_ctrl.sv]
// Sequencing state machine of the attribute span table.
module ast_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    input  ast_pkg::ast_stat_t stat,
    output ast_pkg::ast_ctrl_t ctl
);

    logic [ast_pkg::ST_BITS-1:0] state_reg, state_next;
    logic                        rsp_valid_reg, rsp_valid_next;
    logic                        take, give;

    // Handshakes.
    assign cmd_ready = (state_reg == ast_pkg::ST_IDLE);
    assign take      = cmd_valid && cmd_ready;
    assign give      = (state_reg == ast_pkg::ST_FIN) && (!rsp_valid_reg || rsp_ready);
    assign rsp_valid = rsp_valid_reg;

    assign ctl.op   = state_reg;
    assign ctl.take = take;
    assign ctl.give = give;

    // Output word valid flag.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (give)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ast_pkg::ST_IDLE:   if (take) state_next = ast_pkg::ST_DEC;
            ast_pkg::ST_DEC:
            begin
                if (stat.is_table)
                begin
                    state_next = ast_pkg::ST_G_INIT;
                end
                else if (stat.is_read)
                begin
                    state_next = ast_pkg::ST_R_RD;
                end
                else
                begin
                    state_next = ast_pkg::ST_FIN;
                end
            end
            ast_pkg::ST_G_INIT: state_next = ast_pkg::ST_G_RD;
            ast_pkg::ST_G_RD:
                state_next = stat.g_done ? ast_pkg::ST_S_INIT : ast_pkg::ST_G_W1;
            ast_pkg::ST_G_W1:
                state_next = stat.two_emit ? ast_pkg::ST_G_W2 : ast_pkg::ST_G_RD;
            ast_pkg::ST_G_W2:   state_next = ast_pkg::ST_G_RD;
            ast_pkg::ST_S_INIT: state_next = ast_pkg::ST_S_KEY;
            ast_pkg::ST_S_KEY:
            begin
                if (!stat.s_done)
                begin
                    state_next = ast_pkg::ST_S_KLD;
                end
                else
                begin
                    state_next = stat.is_merge ? ast_pkg::ST_M_INIT : ast_pkg::ST_CHK;
                end
            end
            ast_pkg::ST_S_KLD:  state_next = ast_pkg::ST_S_RDJ;
            ast_pkg::ST_S_RDJ:
                state_next = stat.j_zero ? ast_pkg::ST_S_PUT : ast_pkg::ST_S_CHK;
            ast_pkg::ST_S_CHK:
                state_next = stat.key_gt ? ast_pkg::ST_S_RDJ : ast_pkg::ST_S_PUT;
            ast_pkg::ST_S_PUT:  state_next = ast_pkg::ST_S_KEY;
            ast_pkg::ST_M_INIT: state_next = ast_pkg::ST_M_RD;
            ast_pkg::ST_M_RD:
                state_next = stat.r_done ? ast_pkg::ST_CHK : ast_pkg::ST_M_GRP;
            ast_pkg::ST_M_GRP:
                state_next = stat.new_grp ? ast_pkg::ST_M_PRN : ast_pkg::ST_M_SCAN;
            ast_pkg::ST_M_PRN:  if (stat.p_done) state_next = ast_pkg::ST_M_SCAN;
            ast_pkg::ST_M_SCAN: if (stat.a_done) state_next = ast_pkg::ST_M_ACT;
            ast_pkg::ST_M_ACT:  state_next = ast_pkg::ST_M_RD;
            ast_pkg::ST_CHK:
                state_next = stat.fits ? ast_pkg::ST_C_RD : ast_pkg::ST_FIN;
            ast_pkg::ST_C_RD:
                state_next = stat.c_done ? ast_pkg::ST_FIN : ast_pkg::ST_C_WR;
            ast_pkg::ST_C_WR:   state_next = ast_pkg::ST_C_RD;
            ast_pkg::ST_R_RD:   state_next = ast_pkg::ST_FIN;
            ast_pkg::ST_FIN:    if (give) state_next = ast_pkg::ST_IDLE;
            default:            state_next = ast_pkg::ST_IDLE;
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ast_pkg::ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

[design/ast_dp.sv]
// Datapath of the attribute span table: table memories, work buffer and merge tracker.
module ast_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  ast_pkg::ast_ctrl_t ctl,
    input  ast_pkg::ast_cmd_t  cmd,
    output ast_pkg::ast_stat_t stat,
    output ast_pkg::ast_rsp_t  rsp
);

    localparam int PB  = ast_pkg::POS_BITS;
    localparam int WB  = ast_pkg::WB_BITS;
    localparam int NA  = ast_pkg::NA_BITS;
    localparam int AI  = ast_pkg::AI_BITS;
    localparam int CB  = ast_pkg::CNT_BITS;
    localparam int TA  = ast_pkg::TA_BITS;
    localparam logic [PB+1:0] POS_MAX = {2'b00, {PB{1'b1}}};

    // Saturate an extended position to the position range.
    function automatic logic [PB-1:0] sat_pos(input logic [PB+1:0] x);
        logic [PB-1:0] r;
        r = (x > POS_MAX) ? {PB{1'b1}} : x[PB-1:0];
        return r;
    endfunction

    // Memories.
    ast_pkg::ast_span_t mem_a [ast_pkg::SPAN_ENTRIES];
    ast_pkg::ast_span_t mem_b [ast_pkg::WORK_CAP];
    ast_pkg::ast_span_t a_rdata_reg, b_rdata_reg;
    logic               a_we, a_re, b_we, b_re;
    logic [TA-1:0]      a_waddr, a_raddr;
    logic [WB-1:0]      b_waddr, b_raddr;
    ast_pkg::ast_span_t a_wdata, b_wdata;

    // Command registers.
    logic [2:0]    cmd_reg, cmd_next;
    logic [PB-1:0] s_reg, s_next, e_reg, e_next, cnt_reg, cnt_next;
    logic [7:0]    kind_reg, kind_next;
    logic [31:0]   val_reg, val_next;
    logic [5:0]    idx_reg, idx_next;
    logic [1:0]    status_reg, status_next;

    // Block state.
    logic [CB-1:0] total_reg, total_next;
    logic [PB-1:0] text_reg, text_next;

    // Walk counters.
    logic [CB-1:0] ia_reg, ia_next;
    logic [WB-1:0] bn_reg, bn_next, i_reg, i_next, j_reg, j_next;
    logic [WB-1:0] r_reg, r_next, w_reg, w_next, c_reg, c_next;
    ast_pkg::ast_span_t key_reg, key_next;

    // Merge tracker.
    logic [PB-1:0] pos_reg, pos_next;
    logic          first_reg, first_next;
    logic [NA-1:0] na_reg, na_next, pa_reg, pa_next, keep_reg, keep_next;
    logic [NA-1:0] a_reg, a_next, ins_reg, ins_next;
    logic          found_reg, found_next, insf_reg, insf_next;
    logic [AI-1:0] fidx_reg, fidx_next;
    logic [WB-1:0]      act_idx_reg  [ast_pkg::MAX_ACTIVE];
    logic [WB-1:0]      act_idx_next [ast_pkg::MAX_ACTIVE];
    ast_pkg::ast_span_t act_span_reg  [ast_pkg::MAX_ACTIVE];
    ast_pkg::ast_span_t act_span_next [ast_pkg::MAX_ACTIVE];

    ast_pkg::ast_rsp_t rsp_reg, rsp_next;

    // Clamped range of an incoming command.
    logic [PB-1:0] cs, ce, ce_lim;
    assign cs     = (cmd.range_start < text_reg) ? cmd.range_start : text_reg;
    assign ce_lim = (cmd.range_end > text_reg) ? text_reg : cmd.range_end;
    assign ce     = (ce_lim < cs) ? cs : ce_lim;

    // Shift arithmetic of replace.
    logic [PB-1:0] gone, sh_lo, sh_hi, s_cnt;
    assign gone  = e_reg - s_reg;
    assign sh_lo = sat_pos({2'b00, a_rdata_reg.lo} + {2'b00, cnt_reg} - {2'b00, gone});
    assign sh_hi = sat_pos({2'b00, a_rdata_reg.hi} + {2'b00, cnt_reg} - {2'b00, gone});
    assign s_cnt = sat_pos({2'b00, s_reg} + {2'b00, cnt_reg});

    // Pieces that one old entry leaves after clearing or replacing the range.
    ast_pkg::ast_span_t em1, em2;
    logic [1:0]         em_n;
    logic               any_kind, hit;
    assign any_kind = (cmd_reg == ast_pkg::CMD_CLEAR) && (kind_reg == 8'd0);
    assign hit      = any_kind || (a_rdata_reg.kind == kind_reg);

    always_comb
    begin
        em1  = a_rdata_reg;
        em2  = a_rdata_reg;
        em_n = 2'd1;
        if (cmd_reg == ast_pkg::CMD_REPLACE)
        begin
            if (e_reg <= a_rdata_reg.lo)
            begin
                em1.lo = sh_lo;
                em1.hi = sh_hi;
            end
            else if (s_reg >= a_rdata_reg.hi)
            begin
                em_n = 2'd1;
            end
            else if (s_reg <= a_rdata_reg.lo)
            begin
                if (e_reg < a_rdata_reg.hi)
                begin
                    em1.lo = s_cnt;
                    em1.hi = sh_hi;
                end
                else
                begin
                    em_n = 2'd0;
                end
            end
            else if (e_reg >= a_rdata_reg.hi)
            begin
                em1.hi = s_reg;
            end
            else
            begin
                em1.hi = s_reg;
                em2.lo = s_cnt;
                em2.hi = sh_hi;
                em_n   = 2'd2;
            end
        end
        else
        begin
            if (!hit || s_reg >= e_reg || e_reg <= a_rdata_reg.lo || s_reg >= a_rdata_reg.hi)
            begin
                em_n = 2'd1;
            end
            else if (s_reg <= a_rdata_reg.lo)
            begin
                if (e_reg < a_rdata_reg.hi)
                begin
                    em1.lo = e_reg;
                end
                else
                begin
                    em_n = 2'd0;
                end
            end
            else if (e_reg >= a_rdata_reg.hi)
            begin
                em1.hi = s_reg;
            end
            else
            begin
                em1.hi = s_reg;
                em2.lo = e_reg;
                em_n   = 2'd2;
            end
        end
    end

    // Size of the finished work list.
    logic [WB-1:0] n_cur;
    logic          is_merge;
    assign is_merge = (cmd_reg == ast_pkg::CMD_ADD) || (cmd_reg == ast_pkg::CMD_REPLACE);
    assign n_cur    = is_merge ? w_reg : bn_reg;

    // Status to the controller.
    assign stat.is_table = is_merge || (cmd_reg == ast_pkg::CMD_CLEAR);
    assign stat.is_read  = (cmd_reg == ast_pkg::CMD_READ);
    assign stat.is_merge = is_merge;
    assign stat.g_done   = (ia_reg == total_reg);
    assign stat.two_emit = (em_n == 2'd2);
    assign stat.s_done   = (i_reg >= bn_reg);
    assign stat.j_zero   = (j_reg == '0);
    assign stat.key_gt   = (b_rdata_reg.lo > key_reg.lo);
    assign stat.r_done   = (r_reg == bn_reg);
    assign stat.new_grp  = !first_reg && (b_rdata_reg.lo != pos_reg);
    assign stat.p_done   = (pa_reg == na_reg);
    assign stat.a_done   = (a_reg == na_reg);
    assign stat.fits     = (n_cur <= WB'(ast_pkg::SPAN_ENTRIES));
    assign stat.c_done   = (c_reg == n_cur);

    // Values written back at the end of a command.
    logic [CB-1:0] total_fin;
    logic [PB-1:0] text_fin;
    always_comb
    begin
        total_fin = total_reg;
        text_fin  = text_reg;
        case (cmd_reg)
            ast_pkg::CMD_RESET:
            begin
                total_fin = '0;
                text_fin  = '0;
            end
            ast_pkg::CMD_EXTEND:
                text_fin = sat_pos({2'b00, text_reg} + {2'b00, cnt_reg});
            ast_pkg::CMD_ADD, ast_pkg::CMD_CLEAR:
                if (status_reg == ast_pkg::RSP_OK) total_fin = n_cur[CB-1:0];
            ast_pkg::CMD_REPLACE:
            begin
                if (status_reg == ast_pkg::RSP_OK)
                begin
                    total_fin = n_cur[CB-1:0];
                    text_fin  = sat_pos({2'b00, text_reg} + {2'b00, cnt_reg} - {2'b00, gone});
                end
            end
            default:
            begin
                total_fin = total_reg;
            end
        endcase
    end

    // Operation of each controller step.
    always_comb
    begin
        cmd_next    = cmd_reg;
        s_next      = s_reg;
        e_next      = e_reg;
        cnt_next    = cnt_reg;
        kind_next   = kind_reg;
        val_next    = val_reg;
        idx_next    = idx_reg;
        status_next = status_reg;
        total_next  = total_reg;
        text_next   = text_reg;
        ia_next     = ia_reg;
        bn_next     = bn_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        r_next      = r_reg;
        w_next      = w_reg;
        c_next      = c_reg;
        key_next    = key_reg;
        pos_next    = pos_reg;
        first_next  = first_reg;
        na_next     = na_reg;
        pa_next     = pa_reg;
        keep_next   = keep_reg;
        a_next      = a_reg;
        ins_next    = ins_reg;
        found_next  = found_reg;
        insf_next   = insf_reg;
        fidx_next   = fidx_reg;
        act_idx_next  = act_idx_reg;
        act_span_next = act_span_reg;
        rsp_next    = rsp_reg;
        a_we    = 1'b0;
        a_re    = 1'b0;
        a_waddr = c_reg[TA-1:0];
        a_raddr = ia_reg[TA-1:0];
        a_wdata = b_rdata_reg;
        b_we    = 1'b0;
        b_re    = 1'b0;
        b_waddr = bn_reg;
        b_raddr = i_reg;
        b_wdata = em1;

        case (ctl.op)
            ast_pkg::ST_IDLE:
            begin
                if (ctl.take)
                begin
                    cmd_next    = cmd.command;
                    s_next      = cs;
                    e_next      = ce;
                    cnt_next    = cmd.count;
                    kind_next   = cmd.attr_kind;
                    val_next    = cmd.attr_value;
                    idx_next    = cmd.span_index;
                    status_next = ast_pkg::RSP_OK;
                end
            end
            // Build the work list; an add puts its new span first.
            ast_pkg::ST_G_INIT:
            begin
                ia_next = '0;
                bn_next = '0;
                if (cmd_reg == ast_pkg::CMD_ADD)
                begin
                    b_we    = 1'b1;
                    b_waddr = '0;
                    b_wdata = '{lo: s_reg, hi: e_reg, kind: kind_reg, value: val_reg};
                    bn_next = WB'(1);
                end
            end
            ast_pkg::ST_G_RD:
            begin
                a_re = !stat.g_done;
            end
            ast_pkg::ST_G_W1:
            begin
                ia_next = ia_reg + CB'(1);
                if (em_n != 2'd0)
                begin
                    b_we    = 1'b1;
                    bn_next = bn_reg + WB'(1);
                end
            end
            ast_pkg::ST_G_W2:
            begin
                b_we    = 1'b1;
                b_wdata = em2;
                bn_next = bn_reg + WB'(1);
            end
            // Stable insertion sort of the work list by start.
            ast_pkg::ST_S_INIT:
                i_next = WB'(1);
            ast_pkg::ST_S_KEY:
                b_re = !stat.s_done;
            ast_pkg::ST_S_KLD:
            begin
                key_next = b_rdata_reg;
                j_next   = i_reg;
            end
            ast_pkg::ST_S_RDJ:
            begin
                b_re    = !stat.j_zero;
                b_raddr = j_reg - WB'(1);
            end
            ast_pkg::ST_S_CHK:
            begin
                if (stat.key_gt)
                begin
                    b_we    = 1'b1;
                    b_waddr = j_reg;
                    b_wdata = b_rdata_reg;
                    j_next  = j_reg - WB'(1);
                end
            end
            ast_pkg::ST_S_PUT:
            begin
                b_we    = 1'b1;
                b_waddr = j_reg;
                b_wdata = key_reg;
                i_next  = i_reg + WB'(1);
            end
            // Merge walk, compacting the list in place.
            ast_pkg::ST_M_INIT:
            begin
                r_next     = '0;
                w_next     = '0;
                na_next    = '0;
                first_next = 1'b1;
            end
            ast_pkg::ST_M_RD:
            begin
                b_re    = !stat.r_done;
                b_raddr = r_reg;
            end
            ast_pkg::ST_M_GRP:
            begin
                key_next   = b_rdata_reg;
                first_next = 1'b0;
                if (stat.new_grp)
                begin
                    pa_next   = '0;
                    keep_next = '0;
                end
                else
                begin
                    if (first_reg)
                    begin
                        pos_next = b_rdata_reg.lo;
                    end
                    a_next     = '0;
                    found_next = 1'b0;
                    insf_next  = 1'b0;
                    ins_next   = na_reg;
                end
            end
            // Drop tracked spans that end at or before the closing start.
            ast_pkg::ST_M_PRN:
            begin
                if (!stat.p_done)
                begin
                    if (act_span_reg[pa_reg[AI-1:0]].hi > pos_reg)
                    begin
                        act_span_next[keep_reg[AI-1:0]] = act_span_reg[pa_reg[AI-1:0]];
                        act_idx_next[keep_reg[AI-1:0]]  = act_idx_reg[pa_reg[AI-1:0]];
                        keep_next = keep_reg + NA'(1);
                    end
                    pa_next = pa_reg + NA'(1);
                end
                else
                begin
                    na_next    = keep_reg;
                    pos_next   = key_reg.lo;
                    a_next     = '0;
                    found_next = 1'b0;
                    insf_next  = 1'b0;
                    ins_next   = keep_reg;
                end
            end
            // Look for a touching equal span and the insertion place.
            ast_pkg::ST_M_SCAN:
            begin
                if (!stat.a_done)
                begin
                    if (!found_reg && act_span_reg[a_reg[AI-1:0]].hi == pos_reg &&
                        act_span_reg[a_reg[AI-1:0]].kind == key_reg.kind &&
                        act_span_reg[a_reg[AI-1:0]].value == key_reg.value)
                    begin
                        found_next = 1'b1;
                        fidx_next  = a_reg[AI-1:0];
                    end
                    if (!insf_reg && key_reg.hi < act_span_reg[a_reg[AI-1:0]].hi)
                    begin
                        insf_next = 1'b1;
                        ins_next  = a_reg;
                    end
                    a_next = a_reg + NA'(1);
                end
            end
            ast_pkg::ST_M_ACT:
            begin
                r_next = r_reg + WB'(1);
                b_we   = 1'b1;
                if (found_reg)
                begin
                    act_span_next[fidx_reg].hi = key_reg.hi;
                    b_waddr    = act_idx_reg[fidx_reg];
                    b_wdata    = act_span_reg[fidx_reg];
                    b_wdata.hi = key_reg.hi;
                end
                else
                begin
                    b_waddr = w_reg;
                    b_wdata = key_reg;
                    w_next  = w_reg + WB'(1);
                    if (na_reg < NA'(ast_pkg::MAX_ACTIVE))
                    begin
                        for (int k = 1; k < ast_pkg::MAX_ACTIVE; k++)
                        begin
                            if (k > int'(ins_reg))
                            begin
                                act_span_next[k] = act_span_reg[k-1];
                                act_idx_next[k]  = act_idx_reg[k-1];
                            end
                        end
                        act_span_next[ins_reg[AI-1:0]] = key_reg;
                        act_idx_next[ins_reg[AI-1:0]]  = w_reg;
                        na_next = na_reg + NA'(1);
                    end
                end
            end
            // Capacity check, then copy into the table.
            ast_pkg::ST_CHK:
            begin
                c_next = '0;
                if (!stat.fits)
                begin
                    status_next = ast_pkg::RSP_FULL;
                end
            end
            ast_pkg::ST_C_RD:
            begin
                b_re    = !stat.c_done;
                b_raddr = c_reg;
            end
            ast_pkg::ST_C_WR:
            begin
                a_we   = 1'b1;
                c_next = c_reg + WB'(1);
            end
            ast_pkg::ST_R_RD:
            begin
                a_re    = 1'b1;
                a_raddr = idx_reg[TA-1:0];
                if ({1'b0, idx_reg} >= total_reg)
                begin
                    status_next = ast_pkg::RSP_RANGE;
                end
            end
            // Write back state and load the result word.
            ast_pkg::ST_FIN:
            begin
                if (ctl.give)
                begin
                    total_next           = total_fin;
                    text_next            = text_fin;
                    rsp_next             = '0;
                    rsp_next.status      = status_reg;
                    rsp_next.span_count  = total_fin;
                    rsp_next.text_length = text_fin;
                    if (cmd_reg == ast_pkg::CMD_READ && status_reg == ast_pkg::RSP_OK)
                    begin
                        rsp_next.span_start = a_rdata_reg.lo;
                        rsp_next.span_end   = a_rdata_reg.hi;
                        rsp_next.span_kind  = a_rdata_reg.kind;
                        rsp_next.span_value = a_rdata_reg.value;
                    end
                end
            end
            default:
            begin
                a_re = 1'b0;
            end
        endcase
    end

    // Table memory and work buffer, registered reads.
    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            mem_a[a_waddr] <= a_wdata;
        end
        if (a_re)
        begin
            a_rdata_reg <= mem_a[a_raddr];
        end
        if (b_we)
        begin
            mem_b[b_waddr] <= b_wdata;
        end
        if (b_re)
        begin
            b_rdata_reg <= mem_b[b_raddr];
        end
    end

    // Block state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            text_reg  <= '0;
        end
        else
        begin
            total_reg <= total_next;
            text_reg  <= text_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        s_reg        <= s_next;
        e_reg        <= e_next;
        cnt_reg      <= cnt_next;
        kind_reg     <= kind_next;
        val_reg      <= val_next;
        idx_reg      <= idx_next;
        status_reg   <= status_next;
        ia_reg       <= ia_next;
        bn_reg       <= bn_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        r_reg        <= r_next;
        w_reg        <= w_next;
        c_reg        <= c_next;
        key_reg      <= key_next;
        pos_reg      <= pos_next;
        first_reg    <= first_next;
        na_reg       <= na_next;
        pa_reg       <= pa_next;
        keep_reg     <= keep_next;
        a_reg        <= a_next;
        ins_reg      <= ins_next;
        found_reg    <= found_next;
        insf_reg     <= insf_next;
        fidx_reg     <= fidx_next;
        act_idx_reg  <= act_idx_next;
        act_span_reg <= act_span_next;
        rsp_reg      <= rsp_next;
    end

    assign rsp = rsp_reg;

endmodule
